// ----- rtl/core/em3_pkg.sv -----
// shared types and constants of the 3x3 edge magnitude filter
`timescale 1ns / 1ps
package em3_pkg;

   // image geometry
   localparam int MAX_WIDTH    = 2048;
   localparam int MAX_HEIGHT   = 2048;
   localparam int ADDR_WIDTH   = $clog2(MAX_WIDTH);
   localparam int DIM_WIDTH    = 12;
   localparam int POS_WIDTH    = 11;
   localparam int PIXEL_WIDTH  = 8;
   localparam int DIM_MIN      = 4;
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   // first row and column that yield a result, and the offset to the window's corner
   localparam int OUT_START  = 3;
   localparam int POS_OFFSET = 2;

   // window and queue
   localparam int WIN_TAPS    = 9;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // arithmetic widths
   localparam int GRAD_WIDTH     = 14;
   localparam int SQ_WIDTH       = 26;
   localparam int RADICAND_WIDTH = 16;
   localparam int ROOT_WIDTH     = 8;
   localparam int REM_WIDTH      = 9;
   localparam int SQRT_STEPS     = 8;

   // kernel weights, applied as column and row differences
   localparam logic signed [GRAD_WIDTH-1:0] KX_EDGE   = 14'sd1;
   localparam logic signed [GRAD_WIDTH-1:0] KX_CENTER = 14'sd2;
   localparam logic signed [GRAD_WIDTH-1:0] KY_EDGE   = 14'sd3;
   localparam logic signed [GRAD_WIDTH-1:0] KY_CENTER = 14'sd10;

   // register indexes
   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [PIXEL_WIDTH-1:0] pixel_type;
   typedef pixel_type [WIN_TAPS-1:0] window_type;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel;
      logic                   frame_start;
   } req_type;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] magnitude;
      logic                   saturated;
      logic [POS_WIDTH-1:0]   out_row;
      logic [POS_WIDTH-1:0]   out_col;
   } rsp_type;

   typedef struct packed {
      logic [POS_WIDTH-1:0] row;
      logic [POS_WIDTH-1:0] col;
   } pos_type;

   // one window that yields a result, queued between front and back
   typedef struct packed {
      window_type win;
      pos_type    pos;
   } win_item_type;

endpackage

// ----- rtl/core/em3_front.sv -----
// front end: position counters, line stores and window, classification of each pixel
`timescale 1ns / 1ps
module em3_front
   import em3_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   input  logic                 csr_write_en,
   input  csr_index_type        csr_index,
   input  logic [DIM_WIDTH-1:0] csr_wdata,
   output logic                 push_valid,
   input  logic                 push_ready,
   output win_item_type         push_data
);

   function automatic logic [DIM_WIDTH-1:0] clamp_dim(input logic [DIM_WIDTH-1:0] v,
                                                      input logic [DIM_WIDTH-1:0] maxv);
      logic [DIM_WIDTH-1:0] r;
      begin
         if (v < DIM_WIDTH'(DIM_MIN)) begin
            r = DIM_WIDTH'(DIM_MIN);
         end else if (v > maxv) begin
            r = maxv;
         end else begin
            r = v;
         end
         return r;
      end
   endfunction

   logic [DIM_WIDTH-1:0] width_ff;
   logic [DIM_WIDTH-1:0] height_ff;
   logic [POS_WIDTH-1:0] col_ff, col_in;
   logic [POS_WIDTH-1:0] row_ff, row_in;

   logic                 s1_valid_ff;
   pixel_type            s1_px_ff;
   logic [POS_WIDTH-1:0] s1_x_ff;
   logic [POS_WIDTH-1:0] s1_y_ff;
   pixel_type            rd_a_ff, rd_b_ff;
   logic                 fwd_ff;
   pixel_type            fwd_a_ff, fwd_b_ff;
   window_type           win_ff, win_in;

   pixel_type store_a [MAX_WIDTH];
   pixel_type store_b [MAX_WIDTH];

   logic [DIM_WIDTH-1:0] w_eff, h_eff;
   logic [POS_WIDTH-1:0] col_start, row_start;
   logic [POS_WIDTH-1:0] x_pos, y_pos;
   logic                 col_last, row_last;
   logic                 accept;
   logic                 s1_prod;
   logic                 s1_go;
   pixel_type            above2, above1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_WIDTH'(RESET_WIDTH);
         height_ff <= DIM_WIDTH'(RESET_HEIGHT);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // position of the incoming pixel
   always_comb begin
      w_eff     = clamp_dim(width_ff, DIM_WIDTH'(MAX_WIDTH));
      h_eff     = clamp_dim(height_ff, DIM_WIDTH'(MAX_HEIGHT));
      col_start = req_data.frame_start ? '0 : col_ff;
      row_start = req_data.frame_start ? '0 : row_ff;
      x_pos     = (DIM_WIDTH'(col_start) >= w_eff) ? POS_WIDTH'(w_eff - 1'b1) : col_start;
      y_pos     = (DIM_WIDTH'(row_start) >= h_eff) ? POS_WIDTH'(h_eff - 1'b1) : row_start;
      col_last  = (DIM_WIDTH'(x_pos) + DIM_WIDTH'(1)) >= w_eff;
      row_last  = (DIM_WIDTH'(y_pos) + DIM_WIDTH'(1)) >= h_eff;
      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : y_pos + 1'b1;
      end else begin
         col_in = x_pos + 1'b1;
         row_in = y_pos;
      end
   end

   // window shift and classification of the item in the store stage
   always_comb begin
      above2 = fwd_ff ? fwd_a_ff : rd_a_ff;
      above1 = fwd_ff ? fwd_b_ff : rd_b_ff;
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]     = win_ff[r*3+1];
         win_in[r*3 + 1] = win_ff[r*3+2];
      end
      win_in[2] = above2;
      win_in[5] = above1;
      win_in[8] = s1_px_ff;
      s1_prod   = (s1_y_ff >= POS_WIDTH'(OUT_START)) && (s1_x_ff >= POS_WIDTH'(OUT_START));
      s1_go     = s1_valid_ff && (!s1_prod || push_ready);
   end

   assign req_ready          = !s1_valid_ff || s1_go;
   assign accept             = req_valid && req_ready;
   assign push_valid         = s1_valid_ff && s1_prod;
   assign push_data.win      = win_in;
   assign push_data.pos.row  = s1_y_ff - POS_WIDTH'(POS_OFFSET);
   assign push_data.pos.col  = s1_x_ff - POS_WIDTH'(POS_OFFSET);

   // counters and stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         win_ff      <= '0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
            fwd_ff <= s1_go && (s1_x_ff == x_pos);
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            win_ff <= win_in;
         end
      end
   end

   // stage payload, with bypass of the store write that lands on the same column
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff <= req_data.pixel;
         s1_x_ff  <= x_pos;
         s1_y_ff  <= y_pos;
         fwd_a_ff <= above1;
         fwd_b_ff <= s1_px_ff;
      end
   end

   // line store holding the row two above
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_a_ff <= store_a[x_pos[ADDR_WIDTH-1:0]];
      end
      if (s1_go) begin
         store_a[s1_x_ff[ADDR_WIDTH-1:0]] <= above1;
      end
   end

   // line store holding the row one above
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_b_ff <= store_b[x_pos[ADDR_WIDTH-1:0]];
      end
      if (s1_go) begin
         store_b[s1_x_ff[ADDR_WIDTH-1:0]] <= s1_px_ff;
      end
   end

endmodule

// ----- rtl/core/em3_queue.sv -----
// short queue of windows between front and back
`timescale 1ns / 1ps
module em3_queue
   import em3_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  win_item_type push_data,
   output logic         pop_valid,
   input  logic         pop_ready,
   output win_item_type pop_data
);

   win_item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff;
   logic [QCNT_WIDTH-1:0]   count_ff;
   logic                    do_push;
   logic                    do_pop;

   assign push_ready = count_ff != QCNT_WIDTH'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/em3_back.sv -----
// back end: gradients, squares, saturation and pipelined square root
`timescale 1ns / 1ps
module em3_back
   import em3_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         pop_valid,
   output logic         pop_ready,
   input  win_item_type pop_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   typedef struct packed {
      logic [REM_WIDTH-1:0]      rem;
      logic [ROOT_WIDTH-1:0]     root;
      logic [RADICAND_WIDTH-1:0] n;
      logic                      sat;
      pos_type                   pos;
   } sqrt_stage_type;

   function automatic logic signed [GRAD_WIDTH-1:0] tap(input pixel_type p);
      return signed'(GRAD_WIDTH'(p));
   endfunction

   logic                              advance;

   logic                              g_valid_ff;
   logic signed [GRAD_WIDTH-1:0]      gx_ff, gx_in;
   logic signed [GRAD_WIDTH-1:0]      gy_ff, gy_in;
   pos_type                           g_pos_ff;

   logic                              q_valid_ff;
   logic [SQ_WIDTH-1:0]               sqx_ff, sqy_ff;
   logic signed [2*GRAD_WIDTH-1:0]    sqx_full, sqy_full;
   pos_type                           q_pos_ff;

   logic                              s_valid_ff;
   logic [SQ_WIDTH-1:0]               sum;
   sqrt_stage_type                    s_ff, s_in;

   logic                              r_valid_ff [SQRT_STEPS];
   sqrt_stage_type                    r_ff [SQRT_STEPS];
   sqrt_stage_type                    r_in [SQRT_STEPS];

   logic                              rsp_valid_ff;
   rsp_type                           rsp_data_ff, rsp_data_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign pop_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // gradients as column and row differences of the window
   always_comb begin
      gx_in = KX_EDGE * ((tap(pop_data.win[2]) + tap(pop_data.win[8]))
                         - (tap(pop_data.win[0]) + tap(pop_data.win[6])))
            + KX_CENTER * (tap(pop_data.win[5]) - tap(pop_data.win[3]));
      gy_in = KY_EDGE * ((tap(pop_data.win[6]) + tap(pop_data.win[8]))
                         - (tap(pop_data.win[0]) + tap(pop_data.win[2])))
            + KY_CENTER * (tap(pop_data.win[7]) - tap(pop_data.win[1]));
   end

   // squares and their sum
   always_comb begin
      sqx_full = gx_ff * gx_ff;
      sqy_full = gy_ff * gy_ff;
      sum      = sqx_ff + sqy_ff;
      s_in.rem  = '0;
      s_in.root = '0;
      s_in.n    = sum[RADICAND_WIDTH-1:0];
      s_in.sat  = |sum[SQ_WIDTH-1:RADICAND_WIDTH];
      s_in.pos  = q_pos_ff;
   end

   // one result bit per root stage
   always_comb begin
      sqrt_stage_type            src;
      logic [REM_WIDTH+1:0]      rem_cat;
      logic [REM_WIDTH+1:0]      trial;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         src     = (k == 0) ? s_ff : r_ff[(k == 0) ? 0 : k-1];
         rem_cat = {src.rem, src.n[RADICAND_WIDTH-1 -: 2]};
         trial   = {1'b0, src.root, 2'b01};
         r_in[k] = src;
         r_in[k].n = src.n << 2;
         if (rem_cat >= trial) begin
            r_in[k].rem  = REM_WIDTH'(rem_cat - trial);
            r_in[k].root = {src.root[ROOT_WIDTH-2:0], 1'b1};
         end else begin
            r_in[k].rem  = rem_cat[REM_WIDTH-1:0];
            r_in[k].root = {src.root[ROOT_WIDTH-2:0], 1'b0};
         end
      end
   end

   // result with saturation
   always_comb begin
      rsp_data_in.magnitude = r_ff[SQRT_STEPS-1].sat ? '1 : r_ff[SQRT_STEPS-1].root;
      rsp_data_in.saturated = r_ff[SQRT_STEPS-1].sat;
      rsp_data_in.out_row   = r_ff[SQRT_STEPS-1].pos.row;
      rsp_data_in.out_col   = r_ff[SQRT_STEPS-1].pos.col;
   end

   // stage valids, all moving together when the result register can take data
   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff   <= 1'b0;
         q_valid_ff   <= 1'b0;
         s_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            r_valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         g_valid_ff    <= pop_valid;
         q_valid_ff    <= g_valid_ff;
         s_valid_ff    <= q_valid_ff;
         r_valid_ff[0] <= s_valid_ff;
         for (int k = 1; k < SQRT_STEPS; k++) begin
            r_valid_ff[k] <= r_valid_ff[k-1];
         end
         rsp_valid_ff  <= r_valid_ff[SQRT_STEPS-1];
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         gx_ff       <= gx_in;
         gy_ff       <= gy_in;
         g_pos_ff    <= pop_data.pos;
         sqx_ff      <= sqx_full[SQ_WIDTH-1:0];
         sqy_ff      <= sqy_full[SQ_WIDTH-1:0];
         q_pos_ff    <= g_pos_ff;
         s_ff        <= s_in;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            r_ff[k] <= r_in[k];
         end
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- rtl/core/edge_magnitude_3x3_top.sv -----
// top level of the 3x3 edge magnitude filter
`timescale 1ns / 1ps
// Streaming gradient magnitude over a 3x3 window of 8-bit grey pixels.
// Pixels enter on the req_ channel in raster order; frame_start marks pixel
// (0,0) and restarts the position counters. Each pixel at row and column 3 or
// more yields one transfer on the rsp_ channel: the magnitude of the window
// whose top-left corner is (out_row, out_col), saturated at 255, with the
// saturated flag set when the true value is 256 or more. Other pixels yield
// nothing.
// The csr_ port writes image_width (index 0) and image_height (index 1);
// write it only while the block is idle.
// Throughput is one pixel per cycle while nothing stalls. A result passes
// the front (line store read, window update), the queue, then gradient,
// square, sum, eight root stages and the output register.
// When rsp_ready is low the back pipeline holds, the four-entry queue fills
// and req_ready drops once the front stage cannot hand its window on.
// Reset restores width 640 and height 480, clears counters, window and all
// valids; line stores hold no defined data until a frame has written them.
module edge_magnitude_3x3_top
   import em3_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_write_en,
   input  csr_index_type        csr_index,
   input  logic [DIM_WIDTH-1:0] csr_wdata
);

   logic         push_valid;
   logic         push_ready;
   win_item_type push_data;
   logic         pop_valid;
   logic         pop_ready;
   win_item_type pop_data;

   // position, line stores and window
   em3_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_data    (push_data)
   );

   // windows waiting for the arithmetic
   em3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // gradient magnitude pipeline
   em3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a result never refers to row or column zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_row != '0) && (rsp_data.out_col != '0))
      else $error("result position at the border");

   // a saturated result always reads as full scale
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |-> (rsp_data.magnitude == '1))
      else $error("saturated result below full scale");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule
